FILE: rtl/core/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared constants, register indices and the round/saturate helper for the
// complex moving average filter.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int MAX_WINDOW   = 256;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int SCALE_BITS   = 16;
    localparam int FRAC_BITS    = 15;

    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int ADDR_W = POS_W + CH_W;
    localparam int DEPTH  = MAX_WINDOW * MAX_CHANNELS;

    localparam int LEN_W   = 9;
    localparam int CNT_W   = 4;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // a window holds at most MAX_WINDOW samples per channel
    localparam int SUM_W  = SAMPLE_BITS + POS_W;
    localparam int PROD_W = SUM_W + SCALE_BITS;
    localparam int ACC_W  = PROD_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_SCALE_RE      = 2'd1,
        REG_SCALE_IM      = 2'd2,
        REG_CHANNEL_COUNT = 2'd3
    } cfg_reg_t;

    localparam logic [LEN_W-1:0]      RST_WINDOW_LENGTH = LEN_W'(16);
    localparam logic [SCALE_BITS-1:0] RST_SCALE_RE      = SCALE_BITS'(2048);
    localparam logic [SCALE_BITS-1:0] RST_SCALE_IM      = SCALE_BITS'(0);
    localparam logic [CNT_W-1:0]      RST_CHANNEL_COUNT = CNT_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] val;
        logic                          clip;
    } sat_t;

    // add half an LSB, floor shift, clip to the sample range
    function automatic sat_t round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] rnd;
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        sat_t                    res;
        rnd = ACC_W'(1) <<< (FRAC_BITS - 1);
        hi  = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
        lo  = -hi - ACC_W'(1);
        r   = (v + rnd) >>> FRAC_BITS;
        if (r > hi) begin
            res.val  = hi[SAMPLE_BITS-1:0];
            res.clip = 1'b1;
        end
        else if (r < lo) begin
            res.val  = lo[SAMPLE_BITS-1:0];
            res.clip = 1'b1;
        end
        else begin
            res.val  = r[SAMPLE_BITS-1:0];
            res.clip = 1'b0;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/complex_moving_average.sv
// ----------------------------------------------------------------------------
// complex_moving_average
// Boxcar moving average over complex samples of up to eight interleaved
// channels. Takes one item per clock when not stalled and gives one result
// per item through four register stages: a registered read of the delay
// memory, the running-sum update, the four complex products, then rounding
// and saturation. A stalled result holds each full stage behind it up to the
// first empty one. The delay memory (2048 entries of 32 bits, one write and
// one read port) is cleared after reset by a pass over every entry, one
// entry a cycle; in_stall stays high until it ends, while configuration
// writes are taken throughout. Configuration is to be written only while
// the block is idle.
// ----------------------------------------------------------------------------
module complex_moving_average
(
    input  logic                                     clk,
    input  logic                                     rst_n,

    input  logic                                     cfg_we,
    input  logic [cma_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [cma_pkg::CFG_W-1:0]                cfg_data,

    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [cma_pkg::SAMPLE_BITS-1:0]   sample_re,
    input  logic signed [cma_pkg::SAMPLE_BITS-1:0]   sample_im,

    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [cma_pkg::SAMPLE_BITS-1:0]   avg_re,
    output logic signed [cma_pkg::SAMPLE_BITS-1:0]   avg_im,
    output logic [cma_pkg::CH_W-1:0]                 channel_index,
    output logic                                     saturated
);

    localparam int SB     = cma_pkg::SAMPLE_BITS;
    localparam int SUM_W  = cma_pkg::SUM_W;
    localparam int PROD_W = cma_pkg::PROD_W;
    localparam int ACC_W  = cma_pkg::ACC_W;
    localparam int POS_W  = cma_pkg::POS_W;
    localparam int CH_W   = cma_pkg::CH_W;
    localparam int LEN_W  = cma_pkg::LEN_W;
    localparam int CNT_W  = cma_pkg::CNT_W;
    localparam int ADDR_W = cma_pkg::ADDR_W;
    localparam int SW     = cma_pkg::SCALE_BITS;

    // ---------------- configuration registers ----------------
    logic [LEN_W-1:0]        wl_reg;
    logic signed [SW-1:0]    scale_re_reg;
    logic signed [SW-1:0]    scale_im_reg;
    logic [CNT_W-1:0]        cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg       <= cma_pkg::RST_WINDOW_LENGTH;
            scale_re_reg <= cma_pkg::RST_SCALE_RE;
            scale_im_reg <= cma_pkg::RST_SCALE_IM;
            cnt_reg      <= cma_pkg::RST_CHANNEL_COUNT;
        end
        else if (cfg_we)
        begin
            case (cma_pkg::cfg_reg_t'(cfg_index))
                cma_pkg::REG_WINDOW_LENGTH: wl_reg       <= cfg_data[LEN_W-1:0];
                cma_pkg::REG_SCALE_RE:      scale_re_reg <= cfg_data[SW-1:0];
                cma_pkg::REG_SCALE_IM:      scale_im_reg <= cfg_data[SW-1:0];
                cma_pkg::REG_CHANNEL_COUNT: cnt_reg      <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // window length and channel count clamped to their legal ranges
    logic [LEN_W-1:0] len_eff;
    logic [CNT_W-1:0] cnt_eff;

    always_comb
    begin
        if (wl_reg == '0)
            len_eff = LEN_W'(1);
        else if (wl_reg > LEN_W'(cma_pkg::MAX_WINDOW))
            len_eff = LEN_W'(cma_pkg::MAX_WINDOW);
        else
            len_eff = wl_reg;

        if (cnt_reg == '0)
            cnt_eff = CNT_W'(1);
        else if (cnt_reg > CNT_W'(cma_pkg::MAX_CHANNELS))
            cnt_eff = CNT_W'(cma_pkg::MAX_CHANNELS);
        else
            cnt_eff = cnt_reg;
    end

    // ---------------- pipeline flow control ----------------
    // Each stage moves on when the one after it is empty or moving.
    logic a_v_reg, b_v_reg, c_v_reg, o_v_reg;
    logic o_en, c_en, b_en, a_en;
    logic clr_busy_reg;
    logic in_acc;

    assign o_en     = !o_v_reg || !out_stall;
    assign c_en     = !c_v_reg || o_en;
    assign b_en     = !b_v_reg || c_en;
    assign a_en     = !a_v_reg || b_en;
    assign in_stall = !a_en || clr_busy_reg;
    assign in_acc   = in_valid && !in_stall;

    // ---------------- channel / window position ----------------
    logic [POS_W-1:0] pos_reg, pos_use, pos_next;
    logic [CH_W-1:0]  ch_reg, ch_use, ch_next;
    logic [LEN_W-1:0] pos_inc;
    logic [CNT_W-1:0] ch_inc;

    always_comb
    begin
        // a position beyond a newly shortened limit restarts at zero
        pos_use = (LEN_W'(pos_reg) >= len_eff) ? '0 : pos_reg;
        ch_use  = (CNT_W'(ch_reg) >= cnt_eff) ? '0 : ch_reg;
        ch_inc  = CNT_W'(ch_use) + CNT_W'(1);
        pos_inc = LEN_W'(pos_use) + LEN_W'(1);
        if (ch_inc >= cnt_eff)
        begin
            ch_next  = '0;
            pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
        end
        else
        begin
            ch_next  = ch_inc[CH_W-1:0];
            pos_next = pos_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ch_reg  <= '0;
        end
        else if (in_acc)
        begin
            pos_reg <= pos_next;
            ch_reg  <= ch_next;
        end
    end

    // ---------------- delay memory and clearing pass ----------------
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [2*SB-1:0]   mem [cma_pkg::DEPTH];
    logic [2*SB-1:0]   rd_reg;

    assign wr_addr = {pos_use, ch_use};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(cma_pkg::DEPTH - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // read returns the sample stored one window earlier; new one replaces it
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (in_acc)
        begin
            rd_reg       <= mem[wr_addr];
            mem[wr_addr] <= {sample_im, sample_re};
        end
    end

    // ---------------- stage A: sample and old sample ----------------
    logic signed [SB-1:0] a_re_reg, a_im_reg;
    logic [CH_W-1:0]      a_ch_reg;
    logic signed [SB-1:0] old_re, old_im;

    assign old_re = $signed(rd_reg[SB-1:0]);
    assign old_im = $signed(rd_reg[2*SB-1:SB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (a_en)
            a_v_reg <= in_acc;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_re_reg <= sample_re;
            a_im_reg <= sample_im;
            a_ch_reg <= ch_use;
        end
    end

    // ---------------- stage B: running sums ----------------
    logic signed [SUM_W-1:0] sums_re_reg [cma_pkg::MAX_CHANNELS];
    logic signed [SUM_W-1:0] sums_im_reg [cma_pkg::MAX_CHANNELS];
    logic signed [SUM_W-1:0] sum_re_next, sum_im_next;
    logic signed [SUM_W-1:0] b_sr_reg, b_si_reg;
    logic [CH_W-1:0]         b_ch_reg;
    logic                    b_load;

    assign b_load = b_en && a_v_reg;

    // the sum always stays within the window's range, so wrap-around is exact
    assign sum_re_next = sums_re_reg[a_ch_reg] + SUM_W'(a_re_reg) - SUM_W'(old_re);
    assign sum_im_next = sums_im_reg[a_ch_reg] + SUM_W'(a_im_reg) - SUM_W'(old_im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
            for (int i = 0; i < cma_pkg::MAX_CHANNELS; i++)
            begin
                sums_re_reg[i] <= '0;
                sums_im_reg[i] <= '0;
            end
        end
        else
        begin
            if (b_en)
                b_v_reg <= a_v_reg;
            if (b_load)
            begin
                sums_re_reg[a_ch_reg] <= sum_re_next;
                sums_im_reg[a_ch_reg] <= sum_im_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_sr_reg <= sum_re_next;
            b_si_reg <= sum_im_next;
            b_ch_reg <= a_ch_reg;
        end
    end

    // ---------------- stage C: complex products ----------------
    logic signed [PROD_W-1:0] c_rr_reg, c_ii_reg, c_ri_reg, c_ir_reg;
    logic [CH_W-1:0]          c_ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (c_en)
            c_v_reg <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (c_en && b_v_reg)
        begin
            c_rr_reg <= PROD_W'(b_sr_reg) * PROD_W'(scale_re_reg);
            c_ii_reg <= PROD_W'(b_si_reg) * PROD_W'(scale_im_reg);
            c_ri_reg <= PROD_W'(b_sr_reg) * PROD_W'(scale_im_reg);
            c_ir_reg <= PROD_W'(b_si_reg) * PROD_W'(scale_re_reg);
            c_ch_reg <= b_ch_reg;
        end
    end

    // ---------------- output stage: round and saturate ----------------
    logic signed [ACC_W-1:0] acc_re, acc_im;
    cma_pkg::sat_t           sat_re, sat_im;
    logic signed [SB-1:0]    o_re_reg, o_im_reg;
    logic [CH_W-1:0]         o_ch_reg;
    logic                    o_sat_reg;

    assign acc_re = ACC_W'(c_rr_reg) - ACC_W'(c_ii_reg);
    assign acc_im = ACC_W'(c_ri_reg) + ACC_W'(c_ir_reg);
    assign sat_re = cma_pkg::round_sat(acc_re);
    assign sat_im = cma_pkg::round_sat(acc_im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (o_en)
            o_v_reg <= c_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (o_en && c_v_reg)
        begin
            o_re_reg  <= sat_re.val;
            o_im_reg  <= sat_im.val;
            o_ch_reg  <= c_ch_reg;
            o_sat_reg <= sat_re.clip || sat_im.clip;
        end
    end

    assign out_valid     = o_v_reg;
    assign avg_re        = o_re_reg;
    assign avg_im        = o_im_reg;
    assign channel_index = o_ch_reg;
    assign saturated     = o_sat_reg;

endmodule

FILE: dv/complex_moving_average_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_moving_average_test
// Self-checking bench for the complex boxcar filter. A short table of
// directed items and register writes is run first, then phases of random
// items under random register settings. Every accepted item is run through
// a local model of the running sums and the complex scale; results are
// compared field by field, in order, against the model or a typed-in result.
// ----------------------------------------------------------------------------
module complex_moving_average_test;

    localparam int SAMPLE_BITS  = cma_pkg::SAMPLE_BITS;
    localparam int SCALE_BITS   = cma_pkg::SCALE_BITS;
    localparam int FRAC_BITS    = cma_pkg::FRAC_BITS;
    localparam int CH_W         = cma_pkg::CH_W;
    localparam int CFG_W        = cma_pkg::CFG_W;
    localparam int CFG_IDX_W    = cma_pkg::CFG_IDX_W;
    localparam int LEN_W        = cma_pkg::LEN_W;
    localparam int CNT_W        = cma_pkg::CNT_W;
    localparam int DEPTH        = cma_pkg::DEPTH;
    localparam int MAX_WINDOW   = cma_pkg::MAX_WINDOW;
    localparam int MAX_CHANNELS = cma_pkg::MAX_CHANNELS;

    // run limits
    localparam int          RANDOM_ITEMS = 1500;
    localparam int          IDLE_CYCLES  = 8;       // pipeline is four deep
    localparam int unsigned CYCLE_LIMIT  = 250000;
    localparam int          REPORT_MAX   = 10;

    // Q1.15 rounding and the signed sample range
    localparam longint HALF_LSB   = 64'sd16384;
    localparam longint SAMPLE_MAX = 64'sd32767;
    localparam longint SAMPLE_MIN = -64'sd32768;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic [CH_W-1:0]               ch;
        logic                          sat;
    } avg_item_t;

    typedef enum logic { ROW_SAMPLE, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        cma_pkg::cfg_reg_t             reg_idx;
        logic [CFG_W-1:0]              reg_val;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic                          known;
        avg_item_t                     want;
    } stim_row_t;

    typedef enum int { STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_LIGHT } stall_mode_t;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]              cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] sample_re = '0;
    logic signed [SAMPLE_BITS-1:0] sample_im = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] avg_re;
    logic signed [SAMPLE_BITS-1:0] avg_im;
    logic [CH_W-1:0]               channel_index;
    logic                          saturated;

    // a directed item with a typed-in result travels alongside the payload
    logic      known_flag = 1'b0;
    avg_item_t known_avg  = '0;

    complex_moving_average i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_re     (sample_re),
        .sample_im     (sample_im),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .avg_re        (avg_re),
        .avg_im        (avg_im),
        .channel_index (channel_index),
        .saturated     (saturated)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Filter model: register copies, delay taps and per-channel running sums
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0]             win_len_q   = cma_pkg::RST_WINDOW_LENGTH;
    logic signed [SCALE_BITS-1:0] scale_re_q  = cma_pkg::RST_SCALE_RE;
    logic signed [SCALE_BITS-1:0] scale_im_q  = cma_pkg::RST_SCALE_IM;
    logic [CNT_W-1:0]             chan_cnt_q  = cma_pkg::RST_CHANNEL_COUNT;

    bit signed [SAMPLE_BITS-1:0]  tap_re [DEPTH];
    bit signed [SAMPLE_BITS-1:0]  tap_im [DEPTH];
    longint                       run_re [MAX_CHANNELS];
    longint                       run_im [MAX_CHANNELS];
    int unsigned                  slot = 0;
    int unsigned                  chan = 0;

    avg_item_t   avg_expected_q[$];
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;

    // round half up, floor shift, clip; returns {clipped, value}
    function automatic logic [SAMPLE_BITS:0] round_clip(input longint acc);
        longint r;
        r = (acc + HALF_LSB) >>> FRAC_BITS;
        if (r > SAMPLE_MAX)
            return {1'b1, SAMPLE_BITS'(SAMPLE_MAX)};
        if (r < SAMPLE_MIN)
            return {1'b1, SAMPLE_BITS'(SAMPLE_MIN)};
        return {1'b0, SAMPLE_BITS'(r)};
    endfunction

    function automatic void apply_reg(input cma_pkg::cfg_reg_t idx,
                                      input logic [CFG_W-1:0] val);
        case (idx)
            cma_pkg::REG_WINDOW_LENGTH: win_len_q  = val[LEN_W-1:0];
            cma_pkg::REG_SCALE_RE:      scale_re_q = val;
            cma_pkg::REG_SCALE_IM:      scale_im_q = val;
            cma_pkg::REG_CHANNEL_COUNT: chan_cnt_q = val[CNT_W-1:0];
            default:                    ;
        endcase
    endfunction

    // one item in, one scaled window sum out; advances channel and slot
    function automatic avg_item_t predict_average(
        input logic signed [SAMPLE_BITS-1:0] xr,
        input logic signed [SAMPLE_BITS-1:0] xi);
        int unsigned         len;
        int unsigned         cnt;
        int unsigned         ch;
        int unsigned         addr;
        longint              prod_re;
        longint              prod_im;
        logic [SAMPLE_BITS:0] rr;
        logic [SAMPLE_BITS:0] ri;
        avg_item_t           res;
        len = int'(win_len_q);
        cnt = int'(chan_cnt_q);
        // zero means one, anything past the store means the whole store
        if (len == 0)
            len = 1;
        if (len > MAX_WINDOW)
            len = MAX_WINDOW;
        if (cnt == 0)
            cnt = 1;
        if (cnt > MAX_CHANNELS)
            cnt = MAX_CHANNELS;
        // a shrunk setting restarts an out-of-range pointer at zero
        if (slot >= len)
            slot = 0;
        if (chan >= cnt)
            chan = 0;
        ch   = chan;
        addr = slot * MAX_CHANNELS + ch;
        run_re[ch] += longint'(xr) - longint'(tap_re[addr]);
        run_im[ch] += longint'(xi) - longint'(tap_im[addr]);
        tap_re[addr] = xr;
        tap_im[addr] = xi;
        prod_re = run_re[ch] * longint'(scale_re_q) - run_im[ch] * longint'(scale_im_q);
        prod_im = run_re[ch] * longint'(scale_im_q) + run_im[ch] * longint'(scale_re_q);
        rr = round_clip(prod_re);
        ri = round_clip(prod_im);
        res.re  = rr[SAMPLE_BITS-1:0];
        res.im  = ri[SAMPLE_BITS-1:0];
        res.ch  = CH_W'(ch);
        res.sat = rr[SAMPLE_BITS] | ri[SAMPLE_BITS];
        chan = ch + 1;
        if (chan >= cnt)
        begin
            chan = 0;
            slot++;
            if (slot >= len)
                slot = 0;
        end
        return res;
    endfunction

    task automatic note_fault(input string what, input avg_item_t want, input avg_item_t got);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display({"cycle %0d %s: expected re=%0d im=%0d ch=%0d sat=%0b,",
                      " got re=%0d im=%0d ch=%0d sat=%0b"},
                     cycle_count, what, want.re, want.im, want.ch, want.sat,
                     got.re, got.im, got.ch, got.sat);
    endtask

    // ------------------------------------------------------------------------
    // Checker. Results are checked, register writes mirrored and accepted
    // items predicted all in one process, so the order within an edge is
    // fixed. Everything is sampled as it stood before the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        avg_item_t got;
        avg_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{re: avg_re, im: avg_im, ch: channel_index, sat: saturated};
                if (avg_expected_q.size() == 0)
                    note_fault("result with nothing expected", '0, got);
                else
                begin
                    want = avg_expected_q.pop_front();
                    if (got.re !== want.re || got.im !== want.im ||
                        got.ch !== want.ch || got.sat !== want.sat)
                        note_fault("mismatch", want, got);
                end
            end
            if (cfg_we)
                apply_reg(cma_pkg::cfg_reg_t'(cfg_index), cfg_data);
            if (in_valid && !in_stall)
            begin
                want = predict_average(sample_re, sample_im);
                // the model still advances on rows with a typed-in result
                avg_expected_q.push_back(known_flag ? known_avg : want);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern switches at random among four stall modes
    // ------------------------------------------------------------------------
    initial
    begin : stall_pattern
        stall_mode_t mode;
        int unsigned span;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(10, 150);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
                    default:     out_stall <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    stim_row_t dir_rows[$];

    task automatic add_sample(input logic signed [SAMPLE_BITS-1:0] re,
                              input logic signed [SAMPLE_BITS-1:0] im);
        stim_row_t row;
        row = '{kind: ROW_SAMPLE, reg_idx: cma_pkg::REG_WINDOW_LENGTH, reg_val: '0,
                re: re, im: im, known: 1'b0, want: '0};
        dir_rows.push_back(row);
    endtask

    task automatic add_known(input logic signed [SAMPLE_BITS-1:0] re,
                             input logic signed [SAMPLE_BITS-1:0] im,
                             input avg_item_t want);
        stim_row_t row;
        row = '{kind: ROW_SAMPLE, reg_idx: cma_pkg::REG_WINDOW_LENGTH, reg_val: '0,
                re: re, im: im, known: 1'b1, want: want};
        dir_rows.push_back(row);
    endtask

    task automatic add_reg(input cma_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] val);
        stim_row_t row;
        row = '{kind: ROW_REG, reg_idx: idx, reg_val: val,
                re: '0, im: '0, known: 1'b0, want: '0};
        dir_rows.push_back(row);
    endtask

    // present one item and hold it until taken; also ends any run of writes
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] re,
                               input logic signed [SAMPLE_BITS-1:0] im,
                               input logic known, input avg_item_t want);
        cfg_we     <= 1'b0;
        in_valid   <= 1'b1;
        sample_re  <= re;
        sample_im  <= im;
        known_flag <= known;
        known_avg  <= want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // write enable is left high; the next item or write takes over
    task automatic write_reg(input cma_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // hold off until every expected result is in and the pipeline is empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (avg_expected_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_reg_value(input cma_pkg::cfg_reg_t idx);
        logic [CFG_W-1:0] v;
        v = CFG_W'($urandom);
        case (idx)
            cma_pkg::REG_WINDOW_LENGTH:
            begin
                // mostly short windows so the sums turn over often
                case ($urandom_range(0, 9))
                    0:       v[LEN_W-1:0] = '0;
                    1:       v[LEN_W-1:0] = LEN_W'(MAX_WINDOW);
                    2:       v[LEN_W-1:0] = LEN_W'($urandom_range(MAX_WINDOW + 1, 511));
                    3:       v[LEN_W-1:0] = LEN_W'($urandom_range(9, MAX_WINDOW - 1));
                    default: v[LEN_W-1:0] = LEN_W'($urandom_range(1, 8));
                endcase
            end
            cma_pkg::REG_CHANNEL_COUNT:
            begin
                case ($urandom_range(0, 7))
                    0:       v[CNT_W-1:0] = '0;
                    1:       v[CNT_W-1:0] = CNT_W'($urandom_range(MAX_CHANNELS + 1, 15));
                    default: v[CNT_W-1:0] = CNT_W'($urandom_range(1, MAX_CHANNELS));
                endcase
            end
            default:
            begin
                case ($urandom_range(0, 7))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    3:       v = 16'h4000;   // one half: rounding on odd sums
                    default: ;
                endcase
            end
        endcase
        return v;
    endfunction

    // {re, im}
    function automatic logic [2*SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] re;
        logic [SAMPLE_BITS-1:0] im;
        re = SAMPLE_BITS'($urandom);
        im = SAMPLE_BITS'($urandom);
        case ($urandom_range(0, 9))
            0:
            begin
                re = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                im = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
            1:  im = '0;    // real stream
            2:
            begin
                re = SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
                im = SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
            end
            default: ;
        endcase
        return {re, im};
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned            sent;
        int unsigned            phase_len;
        int unsigned            burst_left;
        int unsigned            gap;
        logic [2*SAMPLE_BITS-1:0] pair;
        bit                     first_phase;
        row_kind_t              last_kind;

        // after reset: window 16, scale 1/16, one channel
        add_known(16, 0, '{re: 1, im: 0, ch: 0, sat: 1'b0});
        add_known(-32768, -32768, '{re: -2047, im: -2048, ch: 0, sat: 1'b0});
        add_sample(32767, 32767);
        add_sample(0, 0);
        // full-scale complex gain: both parts saturate, both directions
        add_reg(cma_pkg::REG_SCALE_RE, 16'h7FFF);
        add_reg(cma_pkg::REG_SCALE_IM, 16'h8000);
        add_sample(32767, -32768);
        add_sample(32767, 32767);
        add_sample(-32768, 32767);
        // channel count above eight is taken as eight
        add_reg(cma_pkg::REG_CHANNEL_COUNT, 16'd9);
        for (int k = 0; k < MAX_CHANNELS; k++)
            add_sample(SAMPLE_BITS'(k * 9000 - 32000), SAMPLE_BITS'(31000 - k * 8000));
        // zero window and zero channels are each taken as one; old taps linger
        add_reg(cma_pkg::REG_WINDOW_LENGTH, 16'd0);
        add_reg(cma_pkg::REG_CHANNEL_COUNT, 16'd0);
        add_sample(-32768, 0);
        add_sample(32767, 0);
        // window past the store, gain of minus one
        add_reg(cma_pkg::REG_WINDOW_LENGTH, 16'h01FF);
        add_reg(cma_pkg::REG_SCALE_RE, 16'h8000);
        add_reg(cma_pkg::REG_SCALE_IM, 16'h0000);
        add_sample(-32768, -32768);
        add_sample(-32768, -32768);
        add_reg(cma_pkg::REG_CHANNEL_COUNT, 16'd15);
        add_sample(1, -1);
        add_sample(-32768, 32767);
        add_sample(32767, -32768);
        // gain of one half on both parts: halves round upwards
        add_reg(cma_pkg::REG_WINDOW_LENGTH, 16'd300);
        add_reg(cma_pkg::REG_SCALE_RE, 16'h4000);
        add_reg(cma_pkg::REG_SCALE_IM, 16'h4000);
        add_reg(cma_pkg::REG_CHANNEL_COUNT, 16'd3);
        add_sample(1, 0);
        add_sample(-1, 0);
        add_sample(3, -3);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; writes only once the block has drained
        last_kind = ROW_SAMPLE;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                if (last_kind == ROW_SAMPLE)
                    wait_idle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
                send_sample(dir_rows[i].re, dir_rows[i].im,
                            dir_rows[i].known, dir_rows[i].want);
            last_kind = dir_rows[i].kind;
        end

        // random phases, each under its own register setting
        sent        = 0;
        burst_left  = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            for (int r = 0; r < 4; r++)
                if (first_phase || $urandom_range(0, 2) == 0)
                    write_reg(cma_pkg::cfg_reg_t'(r),
                              pick_reg_value(cma_pkg::cfg_reg_t'(r)));
            first_phase = 1'b0;
            phase_len   = $urandom_range(40, 250);
            repeat (phase_len)
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 24);
                pair = pick_sample();
                send_sample(pair[2*SAMPLE_BITS-1:SAMPLE_BITS], pair[SAMPLE_BITS-1:0],
                            1'b0, '0);
                sent++;
                burst_left--;
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    if (gap != 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                // now and then let the whole pipeline run dry mid-phase
                if ($urandom_range(0, 199) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
